>>> design/nrc_pkg.sv
// Shared types, codes and widths of the NoC route computation block.
package nrc_pkg;

	localparam int COORD_BITS    = 4;
	localparam int RADIX_BITS    = COORD_BITS + 1;
	localparam int VC_COUNT      = 8;
	localparam int VC_BITS       = (VC_COUNT > 1) ? $clog2(VC_COUNT) : 1;
	localparam int PORT_BITS     = 3;
	localparam int CREDIT_BITS   = 8;
	localparam int ALG_BITS      = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 8;

	// Physical port codes.
	typedef enum logic [PORT_BITS-1:0] {
		PORT_NONE  = 3'd0,
		PORT_WEST  = 3'd1,
		PORT_EAST  = 3'd2,
		PORT_NORTH = 3'd3,
		PORT_SOUTH = 3'd4
	} port_t;

	// Routing algorithm codes; the fourth code is reserved and routes nowhere.
	localparam logic [ALG_BITS-1:0] ALG_TORUS_XY = 2'd0;
	localparam logic [ALG_BITS-1:0] ALG_MESH_YX  = 2'd1;
	localparam logic [ALG_BITS-1:0] ALG_ADAPT_YX = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_X    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Y    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALGORITHM = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [COORD_BITS-1:0] NODE_X_RST    = '0;
	localparam logic [COORD_BITS-1:0] NODE_Y_RST    = '0;
	localparam logic [RADIX_BITS-1:0] RADIX_RST     = RADIX_BITS'(1 << COORD_BITS);
	localparam logic [ALG_BITS-1:0]   ALGORITHM_RST = ALG_MESH_YX;

	typedef struct packed {
		logic [COORD_BITS-1:0] node_x;
		logic [COORD_BITS-1:0] node_y;
		logic [RADIX_BITS-1:0] radix;
		logic [ALG_BITS-1:0]   algorithm;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  dest_x;
		logic [COORD_BITS-1:0]  dest_y;
		logic [PORT_BITS-1:0]   in_port;
		logic [VC_BITS-1:0]     in_vc;
		logic [CREDIT_BITS-1:0] east_credit;
		logic [CREDIT_BITS-1:0] north_credit;
		logic [CREDIT_BITS-1:0] west_credit;
		logic [CREDIT_BITS-1:0] south_credit;
	} flit_t;

	typedef struct packed {
		logic [PORT_BITS-1:0] route_in_port;
		logic [VC_BITS-1:0]   route_in_vc;
		port_t                out_port;
		logic [VC_BITS-1:0]   out_vc;
	} route_t;

endpackage

>>> design/nrc_req_if.sv
// Head flit request channel carrying destination, input port, VC and credits.
interface nrc_req_if
	import nrc_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  dest_x;
	logic [COORD_BITS-1:0]  dest_y;
	logic [PORT_BITS-1:0]   in_port;
	logic [VC_BITS-1:0]     in_vc;
	logic [CREDIT_BITS-1:0] east_credit;
	logic [CREDIT_BITS-1:0] north_credit;
	logic [CREDIT_BITS-1:0] west_credit;
	logic [CREDIT_BITS-1:0] south_credit;

	modport source (output valid, dest_x, dest_y, in_port, in_vc,
		east_credit, north_credit, west_credit, south_credit, input ready);
	modport sink (input valid, dest_x, dest_y, in_port, in_vc,
		east_credit, north_credit, west_credit, south_credit, output ready);
endinterface

>>> design/nrc_rsp_if.sv
// Route result channel carrying the chosen output port and VC.
interface nrc_rsp_if
	import nrc_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [PORT_BITS-1:0] route_in_port;
	logic [VC_BITS-1:0]   route_in_vc;
	logic [PORT_BITS-1:0] out_port;
	logic [VC_BITS-1:0]   out_vc;

	modport source (output valid, route_in_port, route_in_vc, out_port, out_vc,
		input ready);
	modport sink (input valid, route_in_port, route_in_vc, out_port, out_vc,
		output ready);
endinterface

>>> design/nrc_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface nrc_cfg_if
	import nrc_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/nrc_route.sv
// Combinational route decision for one head flit under the current configuration.
module nrc_route
	import nrc_pkg::*;
	(
	input  flit_t  flit,
	input  cfg_t   cfg,
	output route_t route
);

	// Signed offset of the destination from this node along one dimension.
	logic signed [COORD_BITS:0] xoff;
	logic signed [COORD_BITS:0] yoff;
	logic [COORD_BITS-1:0]      xmag;
	logic [COORD_BITS-1:0]      ymag;
	logic                       xneg, xpos, yneg, ypos;
	logic                       xnear, ynear;
	port_t                      xport, yport;
	port_t                      port;

	// Port in one torus dimension: toward the destination on the short side,
	// otherwise the opposite way around the ring.
	function automatic port_t torus_dim(input logic neg, input logic pos,
		input logic near, input port_t neg_port, input port_t pos_port);
		port_t p;
		if (!neg && !pos) begin
			p = PORT_NONE;
		end else if (near) begin
			p = neg ? neg_port : pos_port;
		end else begin
			p = neg ? pos_port : neg_port;
		end
		return p;
	endfunction

	always_comb begin
		xoff  = $signed({1'b0, flit.dest_x}) - $signed({1'b0, cfg.node_x});
		yoff  = $signed({1'b0, flit.dest_y}) - $signed({1'b0, cfg.node_y});
		xneg  = xoff[COORD_BITS];
		yneg  = yoff[COORD_BITS];
		xpos  = !xneg && (xoff != '0);
		ypos  = !yneg && (yoff != '0);
		xmag  = xneg ? COORD_BITS'(-xoff) : COORD_BITS'(xoff);
		ymag  = yneg ? COORD_BITS'(-yoff) : COORD_BITS'(yoff);
		xnear = {xmag, 1'b0} <= cfg.radix;
		ynear = {ymag, 1'b0} <= cfg.radix;
		xport = torus_dim(xneg, xpos, xnear, PORT_WEST, PORT_EAST);
		yport = torus_dim(yneg, ypos, ynear, PORT_NORTH, PORT_SOUTH);

		port = PORT_NONE;
		case (cfg.algorithm)
			ALG_TORUS_XY: begin
				port = (xport != PORT_NONE) ? xport : yport;
			end
			ALG_MESH_YX, ALG_ADAPT_YX: begin
				if (yneg) begin
					if (cfg.algorithm == ALG_ADAPT_YX && xpos &&
						flit.east_credit >= flit.north_credit) begin
						port = PORT_EAST;
					end else begin
						port = PORT_NORTH;
					end
				end else if (ypos) begin
					if (cfg.algorithm == ALG_ADAPT_YX && xneg &&
						flit.west_credit >= flit.south_credit) begin
						port = PORT_WEST;
					end else begin
						port = PORT_SOUTH;
					end
				end else if (xneg) begin
					port = PORT_WEST;
				end else if (xpos) begin
					port = PORT_EAST;
				end
			end
			default: begin
				port = PORT_NONE;
			end
		endcase

		route.route_in_port = flit.in_port;
		route.route_in_vc   = flit.in_vc;
		route.out_port      = port;
		// Torus mode always leaves on VC 0; a flit with no route reports VC 0.
		if (port == PORT_NONE || cfg.algorithm == ALG_TORUS_XY) begin
			route.out_vc = '0;
		end else begin
			route.out_vc = flit.in_vc;
		end
	end

endmodule

>>> design/noc_route_compute_core.sv
// Top level of the NoC route computation block: input stage, route logic, result stage.
//
// Route computation for head flits of a 2-D mesh or torus router. Each word on req
// carries a head flit's destination, its input port and VC, and the credit counts of
// the four neighbours; each word on rsp returns the echoed port and VC with the chosen
// output port (0 none, 1 west, 2 east, 3 north, 4 south) and output VC. The block is
// a two-register pipeline: a word is captured in an input register, routed by a short
// block of logic, and held in a result register until rsp takes it. It accepts one word
// every cycle unless a stall on rsp has filled both registers. When rsp is not stalled,
// a word moves from the input register into the result register and is presented on
// rsp from there. The result register frees the input side while a result waits, so
// a stall on rsp holds off req only once both registers are full. The configuration
// registers (node_x, node_y, radix, algorithm) are written through cfg, which is
// always ready; they must only be written while no word is in flight.
module noc_route_compute_core
	import nrc_pkg::*;
	(
	input logic    clk,
	input logic    arst_n,
	nrc_req_if.sink   req,
	nrc_rsp_if.source rsp,
	nrc_cfg_if.sink   cfg
);

	cfg_t   cfg_q;
	flit_t  flit_s1;
	logic   vld_s1;
	route_t route_s1;
	route_t route_s2;
	logic   vld_s2;
	logic   adv_s2;

	// Configuration registers. Writes are taken every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_x    <= NODE_X_RST;
			cfg_q.node_y    <= NODE_Y_RST;
			cfg_q.radix     <= RADIX_RST;
			cfg_q.algorithm <= ALGORITHM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_NODE_X:    cfg_q.node_x    <= cfg.data[COORD_BITS-1:0];
				CFG_NODE_Y:    cfg_q.node_y    <= cfg.data[COORD_BITS-1:0];
				CFG_RADIX:     cfg_q.radix     <= cfg.data[RADIX_BITS-1:0];
				CFG_ALGORITHM: cfg_q.algorithm <= cfg.data[ALG_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// The result register can take a new word when it is empty or being drained,
	// and the input register can take one when it is empty or moving forward.
	assign adv_s2    = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			flit_s1.dest_x       <= req.dest_x;
			flit_s1.dest_y       <= req.dest_y;
			flit_s1.in_port      <= req.in_port;
			flit_s1.in_vc        <= req.in_vc;
			flit_s1.east_credit  <= req.east_credit;
			flit_s1.north_credit <= req.north_credit;
			flit_s1.west_credit  <= req.west_credit;
			flit_s1.south_credit <= req.south_credit;
		end
	end

	nrc_route u_route (
		.flit  (flit_s1),
		.cfg   (cfg_q),
		.route (route_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			route_s2 <= route_s1;
		end
	end

	assign rsp.valid         = vld_s2;
	assign rsp.route_in_port = route_s2.route_in_port;
	assign rsp.route_in_vc   = route_s2.route_in_vc;
	assign rsp.out_port      = route_s2.out_port;
	assign rsp.out_vc        = route_s2.out_vc;

`ifndef SYNTH
	// A word with no route never reports a VC other than zero.
	a_none_vc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_port == PORT_NONE |-> rsp.out_vc == '0)
		else $error("route with no output port carries a nonzero VC");

	// An accepted word always lands in the input register.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s1)
		else $error("accepted word lost before the input register");

	// A word in the input register moves on whenever the result register frees.
	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("word dropped between input and result registers");

	// The output port code is always one of the five defined ports.
	a_port_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.out_port <= PORT_SOUTH)
		else $error("undefined output port code");
`endif

endmodule

>>> tb/nrc_route_checker.sv
// Route checker for the NoC route computation block: predicts every route word and compares it.
`timescale 1ns / 100ps

module nrc_route_checker
	import nrc_pkg::*;
	(
	input  logic clk,
	input  logic arst_n,
	nrc_req_if   req,
	nrc_rsp_if   rsp,
	nrc_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	logic [COORD_BITS-1:0] cur_node_x;
	logic [COORD_BITS-1:0] cur_node_y;
	logic [RADIX_BITS-1:0] cur_radix;
	logic [ALG_BITS-1:0]   cur_alg;

	route_t expected_routes[$];
	int     errors = 0;

	assign mismatches = errors;

	task automatic report_mismatch(string msg);
		$display("[%0t] route mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// One torus dimension: head toward the destination on the short side of the ring,
	// otherwise wrap around the other way.
	function automatic port_t torus_hop(int off, port_t toward_neg, port_t toward_pos);
		int mag;
		mag = (off < 0) ? -off : off;
		if (off == 0) begin
			return PORT_NONE;
		end
		if (mag * 2 <= int'(cur_radix)) begin
			return (off < 0) ? toward_neg : toward_pos;
		end
		return (off < 0) ? toward_pos : toward_neg;
	endfunction

	function automatic route_t route_for_flit(flit_t f);
		int     xoff;
		int     yoff;
		port_t  hop;
		route_t r;
		xoff = int'(f.dest_x) - int'(cur_node_x);
		yoff = int'(f.dest_y) - int'(cur_node_y);
		hop = PORT_NONE;
		r.out_vc = '0;
		case (cur_alg)
			ALG_TORUS_XY: begin
				hop = torus_hop(xoff, PORT_WEST, PORT_EAST);
				if (hop == PORT_NONE) begin
					hop = torus_hop(yoff, PORT_NORTH, PORT_SOUTH);
				end
			end
			ALG_MESH_YX, ALG_ADAPT_YX: begin
				if (yoff < 0) begin
					hop = (cur_alg == ALG_ADAPT_YX && xoff > 0 &&
						f.east_credit >= f.north_credit) ? PORT_EAST : PORT_NORTH;
				end else if (yoff > 0) begin
					hop = (cur_alg == ALG_ADAPT_YX && xoff < 0 &&
						f.west_credit >= f.south_credit) ? PORT_WEST : PORT_SOUTH;
				end else if (xoff < 0) begin
					hop = PORT_WEST;
				end else if (xoff > 0) begin
					hop = PORT_EAST;
				end
				r.out_vc = f.in_vc;
			end
			default: begin
				hop = PORT_NONE;
			end
		endcase
		if (hop == PORT_NONE) begin
			r.out_vc = '0;
		end
		r.route_in_port = f.in_port;
		r.route_in_vc   = f.in_vc;
		r.out_port      = hop;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		route_t want;
		flit_t  seen;
		if (!arst_n) begin
			cur_node_x  <= NODE_X_RST;
			cur_node_y  <= NODE_Y_RST;
			cur_radix   <= RADIX_RST;
			cur_alg     <= ALGORITHM_RST;
			expected_routes.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_routes.size() == 0) begin
					report_mismatch("route word with no head flit waiting");
				end else begin
					want = expected_routes.pop_front();
					check_field("route_in_port", 8'(rsp.route_in_port), 8'(want.route_in_port));
					check_field("route_in_vc", 8'(rsp.route_in_vc), 8'(want.route_in_vc));
					check_field("out_port", 8'(rsp.out_port), 8'(want.out_port));
					check_field("out_vc", 8'(rsp.out_vc), 8'(want.out_vc));
				end
			end
			if (req.valid && req.ready) begin
				seen.dest_x       = req.dest_x;
				seen.dest_y       = req.dest_y;
				seen.in_port      = req.in_port;
				seen.in_vc        = req.in_vc;
				seen.east_credit  = req.east_credit;
				seen.north_credit = req.north_credit;
				seen.west_credit  = req.west_credit;
				seen.south_credit = req.south_credit;
				expected_routes.push_back(route_for_flit(seen));
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_NODE_X:    cur_node_x <= cfg.data[COORD_BITS-1:0];
					CFG_NODE_Y:    cur_node_y <= cfg.data[COORD_BITS-1:0];
					CFG_RADIX:     cur_radix  <= cfg.data[RADIX_BITS-1:0];
					CFG_ALGORITHM: cur_alg    <= cfg.data[ALG_BITS-1:0];
					default: begin
					end
				endcase
			end
			outstanding <= expected_routes.size();
		end
	end

endmodule

>>> tb/tb.sv
// Testbench top for the NoC route computation block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb
	import nrc_pkg::*;
	();

	// The package names three algorithm codes; the fourth one must route nowhere.
	localparam logic [ALG_BITS-1:0] ALG_RESERVED = 2'd3;

	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_WORDS   = 100;
	localparam int LONG_HOLD     = 60;
	// The block is two registers deep, so this drain wait covers any word in flight.
	localparam int DRAIN_CYCLES  = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nrc_req_if req_ch();
	nrc_rsp_if rsp_ch();
	nrc_cfg_if cfg_ch();

	int fail_count;
	int outstanding;
	int cycle_count = 0;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int stall_pct = 0;
	// Each increment asks the receiver for one long hold-off.
	int holds_asked = 0;

	// Coordinates last written, used to aim destinations at this router now and then.
	logic [COORD_BITS-1:0] node_x_now;
	logic [COORD_BITS-1:0] node_y_now;

	noc_route_compute_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	nrc_route_checker route_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.mismatches  (fail_count),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake or a lost route word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Receiver side of rsp. Ready changes only at the falling edge. A long hold-off is
	// counted down here while the sender keeps offering words, so that both pipeline
	// registers fill up and req has to back off.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// All driving tasks below are entered right after a falling edge and return right
	// after one, so each signal gets at most one assignment per time step.

	// Writes one register and waits for the cfg handshake; valid stays up for the caller.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes all four registers. Only called when no word is in flight.
	task automatic configure(logic [7:0] nx, logic [7:0] ny, logic [7:0] rdx, logic [7:0] alg);
		write_reg(CFG_NODE_X, nx);
		write_reg(CFG_NODE_Y, ny);
		write_reg(CFG_RADIX, rdx);
		write_reg(CFG_ALGORITHM, alg);
		cfg_ch.valid <= 1'b0;
		node_x_now = nx[COORD_BITS-1:0];
		node_y_now = ny[COORD_BITS-1:0];
	endtask

	// Offers one head flit, with random idle cycles in front of it, until req takes it.
	// Valid is left high so that back-to-back words see no bubble.
	task automatic send_flit(flit_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.dest_x       <= f.dest_x;
		req_ch.dest_y       <= f.dest_y;
		req_ch.in_port      <= f.in_port;
		req_ch.in_vc        <= f.in_vc;
		req_ch.east_credit  <= f.east_credit;
		req_ch.north_credit <= f.north_credit;
		req_ch.west_credit  <= f.west_credit;
		req_ch.south_credit <= f.south_credit;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits until every predicted route has come back, then lets the pipeline settle.
	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic flit_t make_flit(int dx, int dy, int port, int vc,
		int e, int n, int w, int s);
		flit_t f;
		f.dest_x       = COORD_BITS'(dx);
		f.dest_y       = COORD_BITS'(dy);
		f.in_port      = PORT_BITS'(port);
		f.in_vc        = VC_BITS'(vc);
		f.east_credit  = CREDIT_BITS'(e);
		f.north_credit = CREDIT_BITS'(n);
		f.west_credit  = CREDIT_BITS'(w);
		f.south_credit = CREDIT_BITS'(s);
		return f;
	endfunction

	// Random head flit. Destinations sometimes share a coordinate with this router so
	// that single-dimension and arrived cases come up often, and credit pairs are
	// sometimes equal so that the adaptive tie goes to the X direction.
	function automatic flit_t random_flit();
		flit_t f;
		f = flit_t'({$urandom, $urandom});
		if ($urandom_range(7) == 0) f.dest_x = node_x_now;
		if ($urandom_range(7) == 0) f.dest_y = node_y_now;
		if ($urandom_range(3) == 0) f.north_credit = f.east_credit;
		if ($urandom_range(3) == 0) f.south_credit = f.west_credit;
		return f;
	endfunction

	task automatic end_burst();
		req_ch.valid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] rdx;
		logic [7:0] alg;
		int mode;

		req_ch.valid        <= 1'b0;
		req_ch.dest_x       <= '0;
		req_ch.dest_y       <= '0;
		req_ch.in_port      <= '0;
		req_ch.in_vc        <= '0;
		req_ch.east_credit  <= '0;
		req_ch.north_credit <= '0;
		req_ch.west_credit  <= '0;
		req_ch.south_credit <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		node_x_now = NODE_X_RST;
		node_y_now = NODE_Y_RST;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling on either side.
		// Reset settings: mesh Y-first at the origin.
		send_flit(make_flit(0, 0, 7, 7, 255, 255, 255, 255));
		send_flit(make_flit(15, 15, 5, 4, 0, 0, 0, 0));
		send_flit(make_flit(15, 0, 6, 0, 255, 0, 0, 255));
		end_burst();

		// Torus X-first in the middle of a 16-node ring: near moves in both dimensions,
		// an offset of exactly half the radix, and a flit already at its destination.
		configure(8'd7, 8'd7, 8'd16, 8'(ALG_TORUS_XY));
		send_flit(make_flit(7, 7, 0, 3, 255, 255, 255, 255));
		send_flit(make_flit(0, 7, 1, 5, 0, 0, 0, 0));
		send_flit(make_flit(15, 7, 2, 7, 255, 0, 255, 0));
		send_flit(make_flit(7, 0, 3, 1, 0, 255, 0, 255));
		send_flit(make_flit(7, 15, 4, 2, 128, 127, 1, 254));
		send_flit(make_flit(15, 15, 0, 6, 255, 255, 0, 0));
		end_burst();

		// Smaller ring: the same offsets now take the wrap-around direction.
		configure(8'd7, 8'd7, 8'd8, 8'(ALG_TORUS_XY));
		send_flit(make_flit(0, 7, 1, 4, 0, 0, 0, 0));
		send_flit(make_flit(7, 15, 2, 3, 0, 0, 0, 0));
		end_burst();

		// Adaptive Y-first: turns east and west on ties, stays in Y when the Y neighbour
		// has more credit, and never turns when X points the other way.
		configure(8'd8, 8'd8, 8'd16, 8'(ALG_ADAPT_YX));
		send_flit(make_flit(15, 0, 0, 1, 255, 255, 0, 0));
		send_flit(make_flit(15, 0, 1, 2, 0, 255, 0, 0));
		send_flit(make_flit(0, 15, 2, 3, 0, 0, 0, 0));
		send_flit(make_flit(0, 15, 3, 4, 0, 0, 0, 1));
		send_flit(make_flit(0, 0, 4, 5, 255, 0, 255, 0));
		end_burst();

		// The reserved algorithm code routes nowhere, even with a real offset.
		configure(8'd3, 8'd3, 8'd16, 8'(ALG_RESERVED));
		send_flit(make_flit(0, 0, 1, 7, 255, 255, 255, 255));
		send_flit(make_flit(3, 3, 6, 6, 0, 0, 0, 0));
		end_burst();

		// Radix outside the legal range is used as written: zero makes every hop wrap,
		// and 31 keeps even the longest offset on the near side.
		configure(8'd0, 8'd0, 8'd0, 8'(ALG_TORUS_XY));
		send_flit(make_flit(1, 0, 2, 1, 0, 0, 0, 0));
		send_flit(make_flit(0, 1, 3, 2, 0, 0, 0, 0));
		end_burst();
		configure(8'd0, 8'd0, 8'd31, 8'(ALG_TORUS_XY));
		send_flit(make_flit(15, 0, 4, 3, 0, 0, 0, 0));
		end_burst();

		// Random part. Each phase writes every register and then sends a burst under
		// one idling pattern; the first phases pin the settings to their extremes.
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: begin nx = 8'd0; ny = 8'd0; rdx = 8'd2; alg = 8'(ALG_TORUS_XY); end
				1: begin nx = 8'd15; ny = 8'd15; rdx = 8'd16; alg = 8'(ALG_ADAPT_YX); end
				2: begin nx = 8'd15; ny = 8'd0; rdx = 8'd31; alg = 8'(ALG_MESH_YX); end
				3: begin nx = 8'd0; ny = 8'd15; rdx = 8'd17; alg = 8'(ALG_TORUS_XY); end
				default: begin
					nx = 8'($urandom_range(255));
					ny = 8'($urandom_range(255));
					if ($urandom_range(3) != 0) begin
						rdx = {3'($urandom_range(7)), 5'($urandom_range(16, 2))};
					end else begin
						rdx = 8'($urandom_range(255));
					end
					alg = 8'($urandom_range(255)) & 8'hFC;
					if ($urandom_range(9) != 0) begin
						alg = alg | 8'($urandom_range(2));
					end else begin
						alg = alg | 8'(ALG_RESERVED);
					end
				end
			endcase
			configure(nx, ny, rdx, alg);

			// Rotate through: no idling, a slow sender, a slow receiver, light idling
			// on both sides.
			mode = k % 4;
			send_idle_pct = (mode == 1) ? 79 : ((mode == 3) ? 8 : 0);
			stall_pct     = (mode == 2) ? 79 : ((mode == 3) ? 8 : 0);

			// Back-pressure: the receiver goes silent for a long stretch while the
			// sender pushes at full rate.
			if (k == 4 || k == 12) begin
				holds_asked++;
			end

			for (int i = 0; i < PHASE_WORDS; i++) begin
				send_flit(random_flit());
			end
			end_burst();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
